FILE: design/alt_pkg.sv
package alt_pkg;

    localparam int ENTRIES     = 8;
    localparam int ENT_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    // wide enough to hold a 3-bit request index and the entry count itself
    localparam int XW          = ((ENT_W > 3) ? ENT_W : 3) + 1;
    localparam int ADDRESSABLE = (ENTRIES < 8) ? ENTRIES : 8;

    localparam logic [31:0] LT_INFINITE = 32'hFFFF_FFFF;
    localparam logic [3:0]  FREED_MAX   = 4'hF;
    localparam logic [7:0]  REFS_MAX    = 8'hFF;

    localparam logic [3:0] ACT_TICK    = 4'd0;
    localparam logic [3:0] ACT_ALLOC   = 4'd1;
    localparam logic [3:0] ACT_CONFIRM = 4'd2;
    localparam logic [3:0] ACT_SET_LT  = 4'd3;
    localparam logic [3:0] ACT_ACQUIRE = 4'd4;
    localparam logic [3:0] ACT_RELEASE = 4'd5;
    localparam logic [3:0] ACT_FREE    = 4'd6;
    localparam logic [3:0] ACT_FLUSH   = 4'd7;
    localparam logic [3:0] ACT_READ    = 4'd8;

    localparam logic [1:0] STS_OK         = 2'd0;
    localparam logic [1:0] STS_NO_FREE    = 2'd1;
    localparam logic [1:0] STS_NOT_IN_USE = 2'd2;

    localparam logic [1:0] AS_TENTATIVE  = 2'd0;
    localparam logic [1:0] AS_PREFERRED  = 2'd1;
    localparam logic [1:0] AS_DEPRECATED = 2'd2;
    localparam logic [1:0] AS_INVALID    = 2'd3;

    typedef struct packed {
        logic [3:0]  action;
        logic [2:0]  entry_index;
        logic [31:0] preferred_lifetime;
        logic [31:0] valid_lifetime;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  result_index;
        logic [1:0]  entry_state;
        logic [31:0] preferred_left;
        logic [31:0] valid_left;
        logic [7:0]  ref_count;
        logic [3:0]  freed_count;
        logic        all_released;
    } t_out_item;

    typedef struct packed {
        logic load_req;
        logic exec;
        logic walk_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic walk_last;
    } t_stat;

endpackage

FILE: design/alt_ctrl.sv
module alt_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [3:0]    i_action,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output alt_pkg::t_cmd o_cmd,
    input  alt_pkg::t_stat i_stat
);
    import alt_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    assign o_cmd.load_req  = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec      = (r_state == S_EXEC);
    assign o_cmd.walk_step = (r_state == S_WALK);
    assign o_cmd.load_out  = (r_state == S_DONE) && out_free;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_action == ACT_TICK || i_action == ACT_FLUSH) begin
                        n_state = S_WALK;
                    end else begin
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
            end
            S_WALK: begin
                if (i_stat.walk_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

FILE: design/alt_dpath.sv
module alt_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  alt_pkg::t_in_item i_in_data,
    output alt_pkg::t_out_item o_out_data,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  alt_pkg::t_cmd     i_cmd,
    output alt_pkg::t_stat    o_stat
);
    import alt_pkg::*;

    logic [ENTRIES-1:0] r_in_use;
    logic [1:0]         r_st    [ENTRIES];
    logic [31:0]        r_pref  [ENTRIES];
    logic [31:0]        r_valid [ENTRIES];
    logic [7:0]         r_refs  [ENTRIES];

    logic [31:0]  r_threshold;
    t_in_item     r_req;
    logic [ENT_W-1:0] r_walk_idx;
    logic [3:0]   r_freed;
    logic         r_any;
    t_out_item    r_res;
    t_out_item    r_out;

    logic [ENT_W-1:0] req_idx;
    logic [ENT_W-1:0] rd_idx;
    logic             idx_ok;
    logic             addr_ok;
    logic             e_in_use;
    logic [1:0]       e_st;
    logic [31:0]      e_pref;
    logic [31:0]      e_valid;
    logic [7:0]       e_refs;

    logic             alloc_found;
    logic [ENT_W-1:0] alloc_idx;

    // one tick of the entry under the walk
    logic [31:0] p_dec;
    logic [31:0] v_dec;
    logic        p_live;
    logic        v_live;
    logic [1:0]  tick_st;
    logic [31:0] tick_pref;
    logic [31:0] tick_valid;

    logic             wr_en;
    logic [ENT_W-1:0] wr_idx;
    logic [1:0]       w_st;
    logic [31:0]      w_pref;
    logic [31:0]      w_valid;
    logic [7:0]       w_refs;
    logic             iu_we;
    logic             iu_val;
    logic [3:0]       freed_inc;
    logic [3:0]       n_freed;
    logic             n_any;
    t_out_item        n_res;
    t_out_item        walk_res;

    assign req_idx  = ENT_W'(r_req.entry_index);
    assign rd_idx   = i_cmd.walk_step ? r_walk_idx : req_idx;
    assign idx_ok   = XW'(r_req.entry_index) < XW'(ENTRIES);
    assign e_in_use = r_in_use[rd_idx];
    assign addr_ok  = idx_ok && e_in_use;
    assign e_st     = r_st[rd_idx];
    assign e_pref   = r_pref[rd_idx];
    assign e_valid  = r_valid[rd_idx];
    assign e_refs   = r_refs[rd_idx];

    assign o_stat.walk_last = (r_walk_idx == ENT_W'(ENTRIES - 1));
    assign o_out_data       = r_out;

    // lowest free index among entries that a result can name
    always_comb begin
        alloc_found = 1'b0;
        alloc_idx   = '0;
        for (int k = ADDRESSABLE - 1; k >= 0; k--) begin
            if (!r_in_use[k]) begin
                alloc_found = 1'b1;
                alloc_idx   = ENT_W'(k);
            end
        end
    end

    always_comb begin
        p_dec      = e_pref - 32'd1;
        v_dec      = e_valid - 32'd1;
        p_live     = (e_pref != LT_INFINITE) && (e_pref != 32'd0);
        v_live     = (e_valid != LT_INFINITE) && (e_valid != 32'd0);
        tick_st    = e_st;
        tick_pref  = p_live ? p_dec : e_pref;
        tick_valid = v_live ? v_dec : e_valid;
        if (p_live && p_dec == 32'd0) begin
            tick_st = AS_DEPRECATED;
        end
        if (v_live && v_dec == r_threshold) begin
            tick_st = AS_INVALID;
        end
    end

    assign freed_inc = (r_freed != FREED_MAX) ? r_freed + 4'd1 : r_freed;

    always_comb begin
        walk_res              = '0;
        walk_res.freed_count  = r_freed;
        walk_res.all_released = (r_req.action == ACT_FLUSH) && !r_any;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_idx  = rd_idx;
        w_st    = e_st;
        w_pref  = e_pref;
        w_valid = e_valid;
        w_refs  = e_refs;
        iu_we   = 1'b0;
        iu_val  = 1'b0;
        n_freed = r_freed;
        n_any   = r_any;
        n_res   = '0;
        if (i_cmd.walk_step) begin
            if (e_in_use) begin
                if (r_req.action == ACT_TICK) begin
                    if (e_st != AS_TENTATIVE) begin
                        wr_en   = 1'b1;
                        w_st    = tick_st;
                        w_pref  = tick_pref;
                        w_valid = tick_valid;
                        if (tick_valid == 32'd0 && e_refs == 8'd0) begin
                            iu_we   = 1'b1;
                            n_freed = freed_inc;
                        end
                    end
                end else if (e_refs == 8'd0) begin
                    iu_we   = 1'b1;
                    n_freed = freed_inc;
                end else begin
                    n_any = 1'b1;
                end
            end
        end else if (i_cmd.exec) begin
            case (r_req.action)
                ACT_ALLOC: begin
                    if (alloc_found) begin
                        wr_en   = 1'b1;
                        wr_idx  = alloc_idx;
                        w_st    = AS_TENTATIVE;
                        w_pref  = '0;
                        w_valid = '0;
                        w_refs  = '0;
                        iu_we   = 1'b1;
                        iu_val  = 1'b1;
                        n_res.result_index = 3'(alloc_idx);
                    end else begin
                        n_res.status = STS_NO_FREE;
                    end
                end
                ACT_CONFIRM, ACT_SET_LT, ACT_ACQUIRE, ACT_RELEASE, ACT_FREE, ACT_READ: begin
                    if (!addr_ok) begin
                        n_res.status = STS_NOT_IN_USE;
                    end else begin
                        case (r_req.action)
                            ACT_CONFIRM: begin
                                if (e_st == AS_TENTATIVE) begin
                                    wr_en  = 1'b1;
                                    w_refs = '0;
                                    w_st   = (e_pref != 32'd0) ? AS_PREFERRED : AS_DEPRECATED;
                                end
                            end
                            ACT_SET_LT: begin
                                wr_en   = 1'b1;
                                w_pref  = r_req.preferred_lifetime;
                                w_valid = r_req.valid_lifetime;
                            end
                            ACT_ACQUIRE: begin
                                if (e_refs != REFS_MAX) begin
                                    wr_en  = 1'b1;
                                    w_refs = e_refs + 8'd1;
                                end
                            end
                            ACT_RELEASE: begin
                                if (e_refs != 8'd0) begin
                                    wr_en  = 1'b1;
                                    w_refs = e_refs - 8'd1;
                                end
                            end
                            ACT_FREE: begin
                                iu_we = 1'b1;
                            end
                            default: begin
                            end
                        endcase
                        n_res.result_index   = r_req.entry_index;
                        n_res.entry_state    = w_st;
                        n_res.preferred_left = w_pref;
                        n_res.valid_left     = w_valid;
                        n_res.ref_count      = w_refs;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use    <= '0;
            r_threshold <= '0;
        end else begin
            if (iu_we) begin
                r_in_use[wr_idx] <= iu_val;
            end
            if (i_cfg_we) begin
                r_threshold <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_st[wr_idx]    <= w_st;
            r_pref[wr_idx]  <= w_pref;
            r_valid[wr_idx] <= w_valid;
            r_refs[wr_idx]  <= w_refs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_req      <= i_in_data;
            r_walk_idx <= '0;
            r_freed    <= '0;
            r_any      <= 1'b0;
        end
        if (i_cmd.walk_step) begin
            r_walk_idx <= r_walk_idx + ENT_W'(1);
            r_freed    <= n_freed;
            r_any      <= n_any;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
        if (i_cmd.load_out) begin
            if (r_req.action == ACT_TICK || r_req.action == ACT_FLUSH) begin
                r_out <= walk_res;
            end else begin
                r_out <= r_res;
            end
        end
    end

endmodule

FILE: design/address_lifetime_table.sv
// channel   direction  handshake                     payload
// in        to block   i_in_valid / o_in_ready       i_in_data  (t_in_item)
// out       from block o_out_valid / i_out_ready     o_out_data (t_out_item)
// cfg       to block   i_cfg_we, no wait             i_cfg_wdata (invalid threshold)
//
// a tick or flush walks the table one entry per cycle, visiting every entry once per request
// every other action reads or writes one entry per request
// one request at a time; a new request is taken while the last result waits in the
// output register, and a finished result waits there until the output side takes it
// synchronous active-low reset clears the in-use marks, the threshold and all control state
module address_lifetime_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  alt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output alt_pkg::t_out_item o_out_data,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata
);
    import alt_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    alt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_action    (i_in_data.action),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    alt_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    a_walk_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.walk_step |-> !o_in_ready)
        else $error("request accepted during table walk");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("pending result overwritten");

    a_walk_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
         (i_in_data.action == ACT_TICK || i_in_data.action == ACT_FLUSH))
        |=> cmd.walk_step)
        else $error("tick or flush did not start a walk");

    a_single_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.load_req, cmd.exec, cmd.walk_step, cmd.load_out}))
        else $error("overlapping datapath commands");

endmodule
